>>> rtl/luf_pkg.sv
// Shared types and constants of the UTF-8 aware line folder.
// Used by the front, the command queue, the back and the top level.
`default_nettype none
package luf_pkg;

	// Default octet count of one character and the ceiling that command records carry.
	localparam int MAX_CHAR_BYTES_DEF = 4;
	localparam int CHAR_BYTES_MAX     = 4;
	localparam int CNT_W              = $clog2(CHAR_BYTES_MAX + 1);
	localparam int SUB_W              = $clog2(CHAR_BYTES_MAX);

	// Command queue depth, a power of two.
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] LIMIT_RESET = 8'd75;
	localparam logic [7:0] LIMIT_FLOOR = 8'd5;
	localparam logic [7:0] CONT_MASK   = 8'hC0;
	localparam logic [7:0] CONT_TAG    = 8'h80;

	localparam logic [7:0] CH_CR = 8'h0D;
	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_SP = 8'h20;

	// One flushed character: optional fold (CR LF SP) ahead of cnt octets.
	typedef struct packed {
		logic                                fold;
		logic [CNT_W-1:0]                    cnt;
		logic [CHAR_BYTES_MAX-1:0][7:0]      bytes;
	} grp_t;

	// Everything one input request sends out: up to two flushes and an optional line end.
	typedef struct packed {
		grp_t a;
		grp_t b;
		logic eol;
	} cmd_t;

endpackage
`default_nettype wire

>>> rtl/utf8_aware_line_folder_unit.sv
// Top level of the UTF-8 aware line folder: front, command queue and back.
// Depends on luf_pkg, luf_front, luf_queue and luf_back.
//
//   channel | direction | handshake            | payload
//   --------+-----------+----------------------+------------------------------
//   in      | sink      | in_valid / in_stall  | in_byte, has_byte, line_end
//   out     | source    | out_valid / out_stall| out_byte, last_of_run
//   cfg     | sink      | cfg_valid / cfg_ready| cfg_data (max_line_octets)
//
// The front takes one request per cycle while the command queue has room;
// the back sends one octet per cycle while out_stall is low; a request causes
// 0 or 1 octets for most bytes, up to 13 at a folded line end.
// The back's single output port sets the sustained rate; an idle back takes a
// command as it reaches the queue head, with no gap between commands otherwise.
// Reset clears held count, line fill, queue and output; the limit returns to 75.
// in_stall rises only when the queue is full; out_stall holds the output register.
`default_nettype none
module utf8_aware_line_folder_unit #(
	parameter int MAX_CHAR_BYTES = luf_pkg::MAX_CHAR_BYTES_DEF
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic [7:0] cfg_data,
	input  wire logic       in_valid,
	output logic            in_stall,
	input  wire logic [7:0] in_byte,
	input  wire logic       has_byte,
	input  wire logic       line_end,
	output logic            out_valid,
	input  wire logic       out_stall,
	output logic [7:0]      out_byte,
	output logic            last_of_run
);

	luf_pkg::cmd_t push_data, pop_data;
	logic          push, full, pop, not_empty;

	// Limit writes land at once; the register never pushes back.
	assign cfg_ready = 1'b1;

	// Classify each request and decide folds against the current line fill.
	luf_front #(
		.MAX_CHAR_BYTES(MAX_CHAR_BYTES)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid && cfg_ready),
		.cfg_data (cfg_data),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_byte  (in_byte),
		.has_byte (has_byte),
		.line_end (line_end),
		.q_full   (full),
		.q_push   (push),
		.q_data   (push_data)
	);

	// Buffer commands so the front keeps taking bytes while the back drains.
	luf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_data(push_data),
		.full     (full),
		.pop      (pop),
		.not_empty(not_empty),
		.pop_data (pop_data)
	);

	// Expand commands into fold, data and line-end octets.
	luf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (not_empty),
		.q_data     (pop_data),
		.q_pop      (pop),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_byte   (out_byte),
		.last_of_run(last_of_run)
	);

endmodule
`default_nettype wire

>>> rtl/luf_front.sv
// Front of the line folder: takes input requests, tracks the held character
// and the line fill, and writes one command per productive request. Uses luf_pkg.
`default_nettype none
module luf_front #(
	parameter int MAX_CHAR_BYTES = luf_pkg::MAX_CHAR_BYTES_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          cfg_valid,
	input  wire logic [7:0]    cfg_data,
	input  wire logic          in_valid,
	output logic               in_stall,
	input  wire logic [7:0]    in_byte,
	input  wire logic          has_byte,
	input  wire logic          line_end,
	input  wire logic          q_full,
	output logic               q_push,
	output luf_pkg::cmd_t      q_data
);

	localparam int HC_W  = $clog2(MAX_CHAR_BYTES + 1);
	localparam int IDX_W = (MAX_CHAR_BYTES > 1) ? $clog2(MAX_CHAR_BYTES) : 1;

	logic [7:0]      held_q [MAX_CHAR_BYTES];
	logic [7:0]      held_n [MAX_CHAR_BYTES];
	logic [HC_W-1:0] hc_q, hc_a, hc_n;
	logic [7:0]      lo_q, lo_a;
	logic [7:0]      max_q, limit;
	logic [8:0]      sum_a, sum_b;
	logic            cont, flush_a, fold_a, flush_b, fold_b, store, accept;

	assign in_stall = q_full;
	assign accept   = in_valid && !in_stall;

	always_comb begin
		limit   = (max_q < luf_pkg::LIMIT_FLOOR) ? luf_pkg::LIMIT_FLOOR : max_q;
		cont    = (in_byte & luf_pkg::CONT_MASK) == luf_pkg::CONT_TAG;
		flush_a = has_byte && (hc_q != '0) && (!cont || hc_q >= HC_W'(MAX_CHAR_BYTES));
		sum_a   = {1'b0, lo_q} + 9'(hc_q);
		fold_a  = flush_a && (sum_a > {1'b0, limit});
		if (!flush_a) begin
			lo_a = lo_q;
		end else if (fold_a) begin
			lo_a = 8'(hc_q) + 8'd1;
		end else begin
			lo_a = sum_a[7:0];
		end
		hc_a = flush_a ? '0 : hc_q;

		// Append the new octet to whatever is left held.
		store  = has_byte && (hc_a < HC_W'(MAX_CHAR_BYTES));
		held_n = held_q;
		if (store) begin
			held_n[hc_a[IDX_W-1:0]] = in_byte;
		end
		hc_n = store ? hc_a + HC_W'(1) : hc_a;

		flush_b = line_end && (hc_n != '0);
		sum_b   = {1'b0, lo_a} + 9'(hc_n);
		fold_b  = flush_b && (sum_b > {1'b0, limit});

		q_data        = '0;
		q_data.a.fold = fold_a;
		q_data.a.cnt  = flush_a ? luf_pkg::CNT_W'(hc_q) : '0;
		q_data.b.fold = fold_b;
		q_data.b.cnt  = flush_b ? luf_pkg::CNT_W'(hc_n) : '0;
		q_data.eol    = line_end;
		for (int i = 0; i < MAX_CHAR_BYTES; i++) begin
			q_data.a.bytes[i] = held_q[i];
			q_data.b.bytes[i] = held_n[i];
		end
		q_push = accept && (flush_a || line_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hc_q  <= '0;
			lo_q  <= '0;
			max_q <= luf_pkg::LIMIT_RESET;
		end else begin
			if (cfg_valid) begin
				max_q <= cfg_data;
			end
			if (accept) begin
				hc_q <= line_end ? '0 : hc_n;
				lo_q <= line_end ? '0 : lo_a;
			end
		end
	end

	// Held octets carry no reset; only entries below the count are read.
	always_ff @(posedge clk) begin
		if (accept) begin
			held_q <= held_n;
		end
	end

endmodule
`default_nettype wire

>>> rtl/luf_queue.sv
// Short command queue between front and back of the line folder.
// Uses luf_pkg for the command type and depth.
`default_nettype none
module luf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire luf_pkg::cmd_t push_data,
	output logic               full,
	input  wire logic          pop,
	output logic               not_empty,
	output luf_pkg::cmd_t      pop_data
);

	localparam int DEPTH = luf_pkg::QUEUE_DEPTH;
	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	luf_pkg::cmd_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push, do_pop;

	assign full      = cnt_q == CNT_W'(DEPTH);
	assign not_empty = cnt_q != '0;
	assign do_push   = push && !full;
	assign do_pop    = pop && not_empty;
	assign pop_data  = mem[rd_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wr_q] <= push_data;
		end
	end

endmodule
`default_nettype wire

>>> rtl/luf_back.sv
// Back of the line folder: walks each queued command octet by octet into
// the output register. Uses luf_pkg.
`default_nettype none
module luf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          q_valid,
	input  wire luf_pkg::cmd_t q_data,
	output logic               q_pop,
	output logic               out_valid,
	input  wire logic          out_stall,
	output logic [7:0]         out_byte,
	output logic               last_of_run
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_FOLD = 4'b0010,
		ST_DATA = 4'b0100,
		ST_EOL  = 4'b1000
	} st_t;

	st_t                       state_q, nst, sst;
	logic                      grp_q, ngrp, sgrp;
	logic [luf_pkg::SUB_W-1:0] sub_q, nsub;
	luf_pkg::cmd_t             cur_q;
	luf_pkg::grp_t             g;
	logic [7:0]                emit;
	logic                      done, busy, advance, step;
	logic                      valid_q, last_q;
	logic [7:0]                byte_q;

	assign busy    = state_q != ST_IDLE;
	assign advance = !valid_q || !out_stall;
	assign step    = busy && advance;
	assign q_pop   = q_valid && (!busy || (step && done));

	assign out_valid   = valid_q;
	assign out_byte    = byte_q;
	assign last_of_run = last_q;

	always_comb begin
		g    = grp_q ? cur_q.b : cur_q.a;
		emit = '0;
		nst  = state_q;
		ngrp = grp_q;
		nsub = sub_q;
		done = 1'b0;
		case (state_q)
			ST_FOLD: begin
				emit = (sub_q == '0) ? luf_pkg::CH_CR :
				       (sub_q == luf_pkg::SUB_W'(1)) ? luf_pkg::CH_LF : luf_pkg::CH_SP;
				if (sub_q < luf_pkg::SUB_W'(2)) begin
					nsub = sub_q + luf_pkg::SUB_W'(1);
				end else begin
					nst  = ST_DATA;
					nsub = '0;
				end
			end
			ST_DATA: begin
				emit = g.bytes[sub_q];
				if (luf_pkg::CNT_W'(sub_q) + luf_pkg::CNT_W'(1) != g.cnt) begin
					nsub = sub_q + luf_pkg::SUB_W'(1);
				end else if (!grp_q && cur_q.b.cnt != '0) begin
					nst  = cur_q.b.fold ? ST_FOLD : ST_DATA;
					ngrp = 1'b1;
					nsub = '0;
				end else if (cur_q.eol) begin
					nst  = ST_EOL;
					nsub = '0;
				end else begin
					done = 1'b1;
				end
			end
			ST_EOL: begin
				emit = (sub_q == '0) ? luf_pkg::CH_CR : luf_pkg::CH_LF;
				if (sub_q == '0) begin
					nsub = luf_pkg::SUB_W'(1);
				end else begin
					done = 1'b1;
				end
			end
			default: begin
				done = 1'b1;
			end
		endcase

		// First step of the next command.
		if (q_data.a.cnt != '0) begin
			sst  = q_data.a.fold ? ST_FOLD : ST_DATA;
			sgrp = 1'b0;
		end else if (q_data.b.cnt != '0) begin
			sst  = q_data.b.fold ? ST_FOLD : ST_DATA;
			sgrp = 1'b1;
		end else begin
			sst  = ST_EOL;
			sgrp = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			grp_q   <= 1'b0;
			sub_q   <= '0;
			valid_q <= 1'b0;
		end else begin
			if (advance) begin
				valid_q <= busy;
			end
			if (q_pop) begin
				state_q <= sst;
				grp_q   <= sgrp;
				sub_q   <= '0;
			end else if (step) begin
				state_q <= done ? ST_IDLE : nst;
				grp_q   <= ngrp;
				sub_q   <= nsub;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			cur_q <= q_data;
		end
		if (advance) begin
			byte_q <= emit;
			last_q <= done;
		end
	end

endmodule
`default_nettype wire

>>> rtl/luf_checker.sv
// Port-level checks of the line folder and the bind that attaches them.
// Depends only on the top level's ports.
`default_nettype none
module luf_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       cfg_valid,
	input wire logic       cfg_ready,
	input wire logic       in_valid,
	input wire logic       in_stall,
	input wire logic [7:0] in_byte,
	input wire logic       has_byte,
	input wire logic       line_end,
	input wire logic       out_valid,
	input wire logic       out_stall,
	input wire logic [7:0] out_byte,
	input wire logic       last_of_run
);

	// No output request shows while reset is applied.
	a_reset_quiet: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("output valid during reset");

	// A full queue means the back is busy, so an output request is showing.
	a_stall_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output is empty");

	// A stalled output request holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_byte) && $stable(last_of_run))
		else $error("stalled output request changed");

	// A stalled input request holds.
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_byte) && $stable(has_byte)
			&& $stable(line_end))
		else $error("stalled input request changed");

	// The limit register always takes writes.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration write refused");

endmodule

bind utf8_aware_line_folder_unit luf_checker u_luf_checker (.*);
`default_nettype wire
